[hw/rtl/cpo_pkg.sv]
// Shared constants, codes and control types of the convex polygon overlap test.
package cpo_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int COORD_WIDTH  = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 5;
	localparam int VERT_W       = 2 * COORD_WIDTH;

	// Query point, edge vector, offset and cross product widths.
	localparam int QW = COORD_WIDTH + 2;
	localparam int EW = COORD_WIDTH + 1;
	localparam int DW = COORD_WIDTH + 3;
	localparam int PW = EW + DW;

	localparam logic CFG_COUNT_A = 1'b0;
	localparam logic CFG_COUNT_B = 1'b1;

	typedef enum logic [1:0] {
		ACT_WR_A    = 2'd0,
		ACT_WR_B    = 2'd1,
		ACT_POINT   = 2'd2,
		ACT_OVERLAP = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		Q_POINT,
		Q_A_IN_B,
		Q_B_IN_A
	} qmode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OUT_RD,
		S_LOADQ,
		S_FIRST,
		S_MUL,
		S_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic [IDX_W-1:0] rd_addr;
		logic             rd_sel_b;
		logic             latch_in;
		logic             load_q;
		qmode_t           qmode;
		logic             load_first;
		logic             mul;
		logic             use_first;
		logic             step;
	} cpo_cmd_t;

	typedef struct packed {
		logic outside;
	} cpo_stat_t;

endpackage

[hw/rtl/cpo_dpath.sv]
// Datapath: vertex stores, query point, edge registers and the shared cross product unit.
module cpo_dpath import cpo_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpo_cmd_t                      cmd,
	input  logic [IDX_W-1:0]              vertex_index,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] pos_a_x,
	input  logic signed [COORD_WIDTH-1:0] pos_a_y,
	input  logic signed [COORD_WIDTH-1:0] pos_b_x,
	input  logic signed [COORD_WIDTH-1:0] pos_b_y,
	output cpo_stat_t                     stat
);

	logic [VERT_W-1:0]       mem_a [MAX_VERTICES];
	logic [VERT_W-1:0]       mem_b [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] valid_a_q;
	logic [MAX_VERTICES-1:0] valid_b_q;
	logic [VERT_W-1:0]       rd_a_q;
	logic [VERT_W-1:0]       rd_b_q;
	logic                    rd_va_q;
	logic                    rd_vb_q;
	logic                    rd_sel_b_q;
	logic [VERT_W-1:0]       rdat;

	logic signed [COORD_WIDTH-1:0] p_x_q, p_y_q, pa_x_q, pa_y_q, pb_x_q, pb_y_q;
	logic signed [QW-1:0]          q_x_q, q_y_q;
	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q;
	logic signed [PW-1:0]          prod1_q, prod2_q;

	logic signed [COORD_WIDTH-1:0] rd_x, rd_y, cur_x, cur_y;
	logic signed [QW-1:0]          base_x, base_y, plus_x, plus_y, minus_x, minus_y;
	logic signed [EW-1:0]          ex, ey;
	logic signed [DW-1:0]          dx, dy;

	// Entries never written since reset read as zero: reset clears these valid bits, not the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a_q <= '0;
			valid_b_q <= '0;
		end else begin
			if (cmd.wr_a) valid_a_q[vertex_index] <= 1'b1;
			if (cmd.wr_b) valid_b_q[vertex_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_a) mem_a[vertex_index] <= {point_y, point_x};
		if (cmd.wr_b) mem_b[vertex_index] <= {point_y, point_x};
		rd_a_q     <= mem_a[cmd.rd_addr];
		rd_b_q     <= mem_b[cmd.rd_addr];
		rd_va_q    <= valid_a_q[cmd.rd_addr];
		rd_vb_q    <= valid_b_q[cmd.rd_addr];
		rd_sel_b_q <= cmd.rd_sel_b;
	end

	always_comb begin
		if (rd_sel_b_q) rdat = rd_vb_q ? rd_b_q : '0;
		else            rdat = rd_va_q ? rd_a_q : '0;
		rd_x = $signed(rdat[COORD_WIDTH-1:0]);
		rd_y = $signed(rdat[VERT_W-1:COORD_WIDTH]);
	end

	// Query point: base plus one position minus the other; for a point test, the point minus position A.
	always_comb begin
		case (cmd.qmode)
			Q_A_IN_B: begin
				base_x  = QW'(rd_x);   base_y  = QW'(rd_y);
				plus_x  = QW'(pa_x_q); plus_y  = QW'(pa_y_q);
				minus_x = QW'(pb_x_q); minus_y = QW'(pb_y_q);
			end
			Q_B_IN_A: begin
				base_x  = QW'(rd_x);   base_y  = QW'(rd_y);
				plus_x  = QW'(pb_x_q); plus_y  = QW'(pb_y_q);
				minus_x = QW'(pa_x_q); minus_y = QW'(pa_y_q);
			end
			default: begin
				base_x  = QW'(p_x_q);  base_y  = QW'(p_y_q);
				plus_x  = '0;          plus_y  = '0;
				minus_x = QW'(pa_x_q); minus_y = QW'(pa_y_q);
			end
		endcase
	end

	always_comb begin
		cur_x = cmd.use_first ? first_x_q : rd_x;
		cur_y = cmd.use_first ? first_y_q : rd_y;
		ex    = EW'(cur_x) - EW'(prev_x_q);
		ey    = EW'(cur_y) - EW'(prev_y_q);
		dx    = DW'(q_x_q) - DW'(prev_x_q);
		dy    = DW'(q_y_q) - DW'(prev_y_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			p_x_q  <= point_x;
			p_y_q  <= point_y;
			pa_x_q <= pos_a_x;
			pa_y_q <= pos_a_y;
			pb_x_q <= pos_b_x;
			pb_y_q <= pos_b_y;
		end
		if (cmd.load_q) begin
			q_x_q <= base_x + plus_x - minus_x;
			q_y_q <= base_y + plus_y - minus_y;
		end
		if (cmd.load_first) begin
			first_x_q <= rd_x;
			first_y_q <= rd_y;
			prev_x_q  <= rd_x;
			prev_y_q  <= rd_y;
		end else if (cmd.step) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.mul) begin
			cur_x_q <= cur_x;
			cur_y_q <= cur_y;
			prod1_q <= PW'(ex) * PW'(dy);
			prod2_q <= PW'(ey) * PW'(dx);
		end
	end

	// A negative edge cross product puts the point outside.
	assign stat.outside = prod1_q < prod2_q;

endmodule

[hw/rtl/cpo_ctrl.sv]
// Controller: count registers, loop counters, sequencing state machine and result register.
module cpo_ctrl import cpo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  act_t             action,
	input  logic [IDX_W-1:0] vertex_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic             write_ignored,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	output cpo_cmd_t         cmd,
	input  cpo_stat_t        stat
);

	state_t           state_q, state_d;
	act_t             act_q;
	logic             phase_q;
	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic [CNT_W-1:0] oi_q, e_q;
	logic             hit_q, ign_q;
	logic             out_valid_q, out_hit_q, out_ign_q;

	logic [CNT_W-1:0] na, nb, n_in, n_out, n_w, e_p1, e_p2;
	logic             inner_is_b, in_acc, is_write, wr_ok, can_load, last_edge, more_outer;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		return (c > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : c;
	endfunction

	always_comb begin
		na         = eff_count(count_a_q);
		nb         = eff_count(count_b_q);
		inner_is_b = (act_q == ACT_OVERLAP) && !phase_q;
		n_in       = inner_is_b ? nb : na;
		n_out      = phase_q ? nb : na;
		e_p1       = e_q + CNT_W'(1);
		e_p2       = e_q + CNT_W'(2);
		last_edge  = e_p1 == n_in;
		more_outer = oi_q < n_out;
		in_acc     = in_valid && (state_q == S_IDLE);
		is_write   = (action == ACT_WR_A) || (action == ACT_WR_B);
		n_w        = (action == ACT_WR_A) ? na : nb;
		wr_ok      = CNT_W'(vertex_index) < n_w;
		can_load   = !out_valid_q || !out_stall;
	end

	assign in_stall      = state_q != S_IDLE;
	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign write_ignored = out_ign_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (action) inside
						ACT_WR_A, ACT_WR_B: state_d = S_DONE;
						ACT_POINT:          state_d = S_LOADQ;
						default:            state_d = S_OUT_RD;
					endcase
				end
			end
			S_OUT_RD: begin
				if (more_outer)    state_d = S_LOADQ;
				else if (phase_q)  state_d = S_DONE;
			end
			S_LOADQ:  state_d = (n_in == '0) ? S_DONE : S_FIRST;
			S_FIRST:  state_d = S_MUL;
			S_MUL:    state_d = S_CMP;
			S_CMP: begin
				if (stat.outside) state_d = (act_q == ACT_POINT) ? S_DONE : S_OUT_RD;
				else if (last_edge) state_d = S_DONE;
				else state_d = S_MUL;
			end
			S_DONE: begin
				if (can_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.qmode      = Q_POINT;
		cmd.rd_sel_b   = inner_is_b;
		cmd.latch_in   = in_acc;
		cmd.wr_a       = in_acc && (action == ACT_WR_A) && wr_ok;
		cmd.wr_b       = in_acc && (action == ACT_WR_B) && wr_ok;
		cmd.use_first  = last_edge;
		unique case (state_q)
			S_OUT_RD: begin
				cmd.rd_addr  = oi_q[IDX_W-1:0];
				cmd.rd_sel_b = phase_q;
			end
			S_LOADQ: begin
				cmd.load_q  = 1'b1;
				cmd.rd_addr = '0;
				if (act_q == ACT_OVERLAP) cmd.qmode = phase_q ? Q_B_IN_A : Q_A_IN_B;
			end
			S_FIRST: begin
				cmd.load_first = 1'b1;
				cmd.rd_addr    = IDX_W'(1);
			end
			S_MUL: cmd.mul = 1'b1;
			S_CMP: begin
				cmd.step    = 1'b1;
				cmd.rd_addr = e_p2[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_WR_A;
			phase_q     <= 1'b0;
			count_a_q   <= '0;
			count_b_q   <= '0;
			oi_q        <= '0;
			e_q         <= '0;
			hit_q       <= 1'b0;
			ign_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_ign_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_COUNT_A) count_a_q <= cfg_data;
				else                          count_b_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						act_q   <= action;
						phase_q <= 1'b0;
						oi_q    <= '0;
						hit_q   <= 1'b0;
						ign_q   <= is_write && !wr_ok;
					end
				end
				S_OUT_RD: begin
					if (!more_outer && !phase_q) begin
						phase_q <= 1'b1;
						oi_q    <= '0;
					end
				end
				S_LOADQ: begin
					e_q <= '0;
					// An empty polygon holds every point.
					if (n_in == '0) hit_q <= 1'b1;
				end
				S_CMP: begin
					if (stat.outside) oi_q <= oi_q + CNT_W'(1);
					else if (last_edge) hit_q <= 1'b1;
					else e_q <= e_p1;
				end
				default: ;
			endcase
			if (state_q == S_DONE && can_load) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
				out_ign_q   <= ign_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/convex_polygon_overlap_test.sv]
// Top level of the convex polygon overlap test: controller and datapath.
//
// Usage: items arrive on in_valid/in_stall with action, vertex_index, point
// and the two polygon positions; one result (hit, write_ignored) leaves on
// out_valid/out_stall for every item. A transfer happens on a clock edge with
// valid high and stall low. count_a and count_b are written through cfg_we,
// cfg_index and cfg_data only while the block is idle; the user must keep to
// this, as the block does not enforce it. The block works on one item at a
// time; in_stall is high from the cycle after a transfer until the result is
// loaded into the output register, so the next item is taken while a finished
// result still waits. A vertex write goes straight to the result. A point test
// loads the query point, reads the first vertex of A and then takes a multiply
// state and a compare state per edge of A; an empty A is a hit. An overlap
// test visits each vertex of A against B, then each vertex of B against A,
// taking those steps over the inner polygon's edges through the shared cross
// product unit and the single read port of each vertex store. A point test
// stops at the first edge that puts the point outside; an overlap test moves
// on to the next vertex there and stops at the first vertex found inside.
// Reset clears both counts, the vertex stores' valid bits (read as zero until
// written) and the output register. While out_stall is high the result holds.
module convex_polygon_overlap_test import cpo_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [IDX_W-1:0]              vertex_index,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] pos_a_x,
	input  logic signed [COORD_WIDTH-1:0] pos_a_y,
	input  logic signed [COORD_WIDTH-1:0] pos_b_x,
	input  logic signed [COORD_WIDTH-1:0] pos_b_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic                          write_ignored,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [CNT_W-1:0]              cfg_data
);

	cpo_cmd_t  cmd;
	cpo_stat_t stat;

	cpo_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (act_t'(action)),
		.vertex_index  (vertex_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.write_ignored (write_ignored),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat)
	);

	cpo_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.pos_a_x      (pos_a_x),
		.pos_a_y      (pos_a_y),
		.pos_b_x      (pos_b_x),
		.pos_b_y      (pos_b_y),
		.stat         (stat)
	);

`ifndef SYNTH
	a_no_hit_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && write_ignored))
		else $error("result flags both a hit and an ignored write");

	a_write_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_a || cmd.wr_b) |-> (in_valid && !in_stall))
		else $error("vertex store written without an input transfer");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after an input transfer");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");
`endif

endmodule

[tb/sv/convex_polygon_overlap_test_tb.sv]
// Self-checking testbench for the convex polygon overlap test block.
`timescale 1ns / 1ps

module convex_polygon_overlap_test_tb import cpo_pkg::*; ();

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [CNT_W-1:0]              cnt_t;

	typedef struct packed {
		logic hit;
		logic write_ignored;
	} verdict_t;

	localparam int STALL_LIMIT = 6000;
	localparam int RANDOM_ITEMS = 1170;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	logic   [1:0] action = 2'd0;
	idx_t   vertex_index = '0;
	coord_t point_x = '0;
	coord_t point_y = '0;
	coord_t pos_a_x = '0;
	coord_t pos_a_y = '0;
	coord_t pos_b_x = '0;
	coord_t pos_b_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   hit;
	logic   write_ignored;
	logic   cfg_we = 1'b0;
	logic   cfg_index = CFG_COUNT_A;
	cnt_t   cfg_data = '0;

	// Predicted copy of the block's vertex stores and counts.
	coord_t shape_a_x [MAX_VERTICES];
	coord_t shape_a_y [MAX_VERTICES];
	coord_t shape_b_x [MAX_VERTICES];
	coord_t shape_b_y [MAX_VERTICES];
	cnt_t   verts_in_a;
	cnt_t   verts_in_b;

	verdict_t pending_verdicts [$];
	verdict_t want;
	int       errors = 0;
	int       stall_cnt = 0;
	int       quiet_cycles = 0;
	bit       quiet = 1'b0;

	convex_polygon_overlap_test uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.vertex_index (vertex_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.pos_a_x      (pos_a_x),
		.pos_a_y      (pos_a_y),
		.pos_b_x      (pos_b_x),
		.pos_b_y      (pos_b_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.write_ignored(write_ignored),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int span(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// No gap while quiet; otherwise mostly none, often a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = span(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return span(1, 3);
		return span(8, 40);
	endfunction

	function automatic int usable(cnt_t c);
		return (int'(c) > MAX_VERTICES) ? MAX_VERTICES : int'(c);
	endfunction

	// A point is outside as soon as one edge leaves it strictly on its right.
	function automatic bit in_poly(bit of_b, int n, longint qx, longint qy);
		longint x0, y0, x1, y1;
		int j;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			x0 = of_b ? shape_b_x[i] : shape_a_x[i];
			y0 = of_b ? shape_b_y[i] : shape_a_y[i];
			x1 = of_b ? shape_b_x[j] : shape_a_x[j];
			y1 = of_b ? shape_b_y[j] : shape_a_y[j];
			if ((x1 - x0) * (qy - y0) < (y1 - y0) * (qx - x0))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic verdict_t apply_item(act_t op, idx_t idx, coord_t px, coord_t py,
			coord_t ax, coord_t ay, coord_t bx, coord_t by);
		verdict_t v;
		int na, nb;
		na = usable(verts_in_a);
		nb = usable(verts_in_b);
		v = '0;
		case (op)
			ACT_WR_A: begin
				if (int'(idx) < na) begin
					shape_a_x[idx] = px;
					shape_a_y[idx] = py;
				end else begin
					v.write_ignored = 1'b1;
				end
			end
			ACT_WR_B: begin
				if (int'(idx) < nb) begin
					shape_b_x[idx] = px;
					shape_b_y[idx] = py;
				end else begin
					v.write_ignored = 1'b1;
				end
			end
			ACT_POINT: begin
				v.hit = in_poly(1'b0, na, longint'(px) - longint'(ax),
					longint'(py) - longint'(ay));
			end
			default: begin
				for (int i = 0; i < na && !v.hit; i++)
					if (in_poly(1'b1, nb, longint'(shape_a_x[i]) + ax - bx,
							longint'(shape_a_y[i]) + ay - by))
						v.hit = 1'b1;
				for (int i = 0; i < nb && !v.hit; i++)
					if (in_poly(1'b0, na, longint'(shape_b_x[i]) + bx - ax,
							longint'(shape_b_y[i]) + by - ay))
						v.hit = 1'b1;
			end
		endcase
		return v;
	endfunction

	task automatic send_item(act_t op, int idx, int px, int py, int ax, int ay, int bx, int by);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= op;
		vertex_index <= idx_t'(idx);
		point_x <= coord_t'(px);
		point_y <= coord_t'(py);
		pos_a_x <= coord_t'(ax);
		pos_a_y <= coord_t'(ay);
		pos_b_x <= coord_t'(bx);
		pos_b_y <= coord_t'(by);
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_verdicts.push_back(apply_item(op, idx_t'(idx), coord_t'(px), coord_t'(py),
			coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by)));
	endtask

	// Always waits on the clock before checking the queue, so the next drive lands in a later step.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
	endtask

	task automatic load_counts(int a, int b);
		hold_until_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_COUNT_A;
		cfg_data <= cnt_t'(a);
		@(posedge clk);
		verts_in_a = cnt_t'(a);
		cfg_index <= CFG_COUNT_B;
		cfg_data <= cnt_t'(b);
		@(posedge clk);
		verts_in_b = cnt_t'(b);
		cfg_we <= 1'b0;
	endtask

	// Vertices on a jittered circle, counterclockwise unless flipped, or anywhere at random when scrambled.
	task automatic write_polygon(act_t op, int n, int cx, int cy, int rad, bit scramble);
		real step_ang, ang;
		int x, y;
		bit cw;
		cw = (span(0, 7) == 0);
		step_ang = 6.283185307179586 / n;
		for (int k = 0; k < n; k++) begin
			ang = step_ang * (k + span(-300, 300) / 1000.0);
			if (cw)
				ang = -ang;
			x = cx + $rtoi(rad * $cos(ang));
			y = cy + $rtoi(rad * $sin(ang));
			if (scramble) begin
				x = span(-32768, 32767);
				y = span(-32768, 32767);
			end
			send_item(op, k, x, y, span(-32768, 32767), span(-32768, 32767),
				span(-32768, 32767), span(-32768, 32767));
		end
	endtask

	function automatic int pick_count();
		int r;
		r = span(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return MAX_VERTICES;
		if (r == 2)
			return span(MAX_VERTICES + 1, 31);
		if (r == 3)
			return span(1, 2);
		return span(3, 8);
	endfunction

	task automatic test_reset_state();
		// Both counts are zero: writes bounce, every point is inside, no overlap.
		send_item(ACT_WR_A, 0, 5, 5, 0, 0, 0, 0);
		send_item(ACT_WR_B, 5, -5, -5, 0, 0, 0, 0);
		send_item(ACT_POINT, 15, 32767, -32768, -32768, 32767, 32767, -32768);
		send_item(ACT_OVERLAP, 0, 0, 0, 100, 100, -100, -100);
	endtask

	task automatic test_vertex_store();
		load_counts(4, 3);
		send_item(ACT_WR_A, 0, -32768, -32768, 0, 0, 0, 0);
		send_item(ACT_WR_A, 1, 32767, -32768, 0, 0, 0, 0);
		send_item(ACT_WR_A, 2, 32767, 32767, 0, 0, 0, 0);
		send_item(ACT_WR_A, 3, -32768, 32767, 0, 0, 0, 0);
		send_item(ACT_WR_A, 4, 1, 1, 0, 0, 0, 0);
		send_item(ACT_WR_A, 15, 1, 1, 0, 0, 0, 0);
		send_item(ACT_WR_B, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_WR_B, 1, 100, 0, 0, 0, 0, 0);
		send_item(ACT_WR_B, 2, 0, 100, 0, 0, 0, 0);
		send_item(ACT_WR_B, 3, 7, 7, 0, 0, 0, 0);
	endtask

	task automatic test_point_in_a();
		send_item(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_POINT, 0, 32767, 0, 0, 0, 0, 0);
		send_item(ACT_POINT, 0, 32767, 0, -1, 0, 0, 0);
		send_item(ACT_POINT, 0, -32768, 32767, 0, 0, 0, 0);
	endtask

	task automatic test_overlap();
		send_item(ACT_OVERLAP, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_OVERLAP, 0, 0, 0, -32768, -32768, 32767, 32767);
	endtask

	task automatic test_counts_over_store();
		// Counts beyond the store act as a full store.
		load_counts(31, 17);
		send_item(ACT_WR_A, 15, 12, -40, 0, 0, 0, 0);
		send_item(ACT_POINT, 3, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_degenerate();
		load_counts(1, 2);
		send_item(ACT_POINT, 0, -32768, -32768, -32768, -32768, 0, 0);
		send_item(ACT_POINT, 0, 50, 50, 0, 0, 0, 0);
		send_item(ACT_OVERLAP, 0, 0, 0, 10, 10, 10, 10);
		load_counts(0, 3);
		send_item(ACT_OVERLAP, 0, 0, 0, 500, -500, 0, 0);
	endtask

	task automatic test_random_phases();
		int ca, cb, na, nb, cxa, cya, ra, cxb, cyb, rb;
		int queries, pause_at, pick, ax, ay, bx, by, k, px, py;
		int sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			ca = pick_count();
			cb = pick_count();
			load_counts(ca, cb);
			quiet = (span(0, 3) == 0);
			na = usable(cnt_t'(ca));
			nb = usable(cnt_t'(cb));
			cxa = span(-6000, 6000);
			cya = span(-6000, 6000);
			cxb = span(-6000, 6000);
			cyb = span(-6000, 6000);
			ra = (span(0, 3) == 0) ? span(16, 200) : span(200, 5000);
			rb = (span(0, 3) == 0) ? span(16, 200) : span(200, 5000);
			if (na > 0)
				write_polygon(ACT_WR_A, na, cxa, cya, ra, span(0, 9) == 0);
			if (nb > 0)
				write_polygon(ACT_WR_B, nb, cxb, cyb, rb, span(0, 9) == 0);
			sent += na + nb;
			queries = span(50, 100);
			pause_at = span(0, queries - 1);
			for (int q = 0; q < queries; q++) begin
				if (q == pause_at)
					hold_until_drained();
				pick = span(0, 99);
				ax = span(-3000, 3000);
				ay = span(-3000, 3000);
				bx = span(-3000, 3000);
				by = span(-3000, 3000);
				if (pick < 10) begin
					send_item(act_t'(span(0, 3)), span(0, 15), span(-32768, 32767),
						span(-32768, 32767), span(-32768, 32767), span(-32768, 32767),
						span(-32768, 32767), span(-32768, 32767));
				end else if (pick < 16 && na < MAX_VERTICES) begin
					send_item(ACT_WR_A, span(na, 15), span(-32768, 32767),
						span(-32768, 32767), ax, ay, bx, by);
				end else if (pick < 22 && nb < MAX_VERTICES) begin
					send_item(ACT_WR_B, span(nb, 15), span(-32768, 32767),
						span(-32768, 32767), ax, ay, bx, by);
				end else if (pick < 70) begin
					if (na > 0 && span(0, 4) == 0) begin
						// Stored vertices lie on the boundary.
						k = span(0, na - 1);
						px = ax + shape_a_x[k];
						py = ay + shape_a_y[k];
					end else begin
						px = ax + cxa + span(-ra * 13 / 10, ra * 13 / 10);
						py = ay + cya + span(-ra * 13 / 10, ra * 13 / 10);
					end
					send_item(ACT_POINT, span(0, 15), px, py, ax, ay, bx, by);
				end else begin
					bx = ax + cxa - cxb + span(-(ra + rb), ra + rb);
					by = ay + cya - cyb + span(-(ra + rb), ra + rb);
					send_item(ACT_OVERLAP, span(0, 15), span(-32768, 32767),
						span(-32768, 32767), ax, ay, bx, by);
				end
			end
			sent += queries;
		end
		quiet = 1'b0;
	endtask

	// Receiver: runs of acceptance broken by stalls of random length.
	always @(posedge clk) begin
		if (stall_cnt != 0) begin
			out_stall <= 1'b1;
			stall_cnt <= stall_cnt - 1;
		end else begin
			out_stall <= 1'b0;
			if (span(0, 3) == 0)
				stall_cnt <= idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result transfer: hit=%0b write_ignored=%0b",
					$time, hit, write_ignored);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (hit !== want.hit) begin
					$display("%0t: hit expected %0b, actual %0b", $time, want.hit, hit);
					errors++;
				end
				if (write_ignored !== want.write_ignored) begin
					$display("%0t: write_ignored expected %0b, actual %0b",
						$time, want.write_ignored, write_ignored);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			shape_a_x[i] = '0;
			shape_a_y[i] = '0;
			shape_b_x[i] = '0;
			shape_b_y[i] = '0;
		end
		verts_in_a = '0;
		verts_in_b = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_vertex_store();
		test_point_in_a();
		test_overlap();
		test_counts_over_store();
		test_degenerate();
		test_random_phases();
		hold_until_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
